// ===== rtl/rmq_pkg.sv =====
// Package for the rotation-matrix-to-quaternion block.
// Holds the payload structs, the branch codes and the stage control struct.
// No dependencies.
`default_nettype none
package rmq_pkg;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } rmq_in_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic [1:0]         branch_used;
  } rmq_out_t;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

  // Per-slot control riding alongside the data through the pipeline.
  typedef struct packed {
    logic    valid;
    branch_t branch;
  } rmq_ctl_t;

  localparam int NUM_W = 18;  // numerator width (sums of two 16-bit values)
  localparam int QUOT_W = 17; // quotient magnitude width before saturation

endpackage
`default_nettype wire

// ===== rtl/rmq_sqrt.sv =====
// Pipelined restoring square root, one result bit per stage.
// Depends on rmq_pkg. Root of a RAD_W-bit unsigned radicand.
`default_nettype none
module rmq_sqrt #(
  parameter int RAD_W = 34,
  parameter int SIDE_W = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  input  wire logic [RAD_W-1:0]       rad,
  input  wire logic [SIDE_W-1:0]      side_in,
  output logic                        out_valid,
  output logic [(RAD_W+1)/2-1:0]      root,
  output logic [SIDE_W-1:0]           side_out
);
  import rmq_pkg::*;

  localparam int N = (RAD_W + 1) / 2;
  localparam int PW = 2 * N;

  logic [PW-1:0]     rem_q  [N+1];
  logic [PW-1:0]     val_q  [N+1];
  logic [N-1:0]      res_q  [N+1];
  logic [SIDE_W-1:0] side_q [N+1];
  logic              vld_q  [N+1];

  always_comb begin
    rem_q[0]  = '0;
    val_q[0]  = PW'(rad);
    res_q[0]  = '0;
    side_q[0] = side_in;
    vld_q[0]  = in_valid;
  end

  // Stage k brings down two radicand bits and decides one root bit.
  for (genvar k = 0; k < N; k++) begin : g_st
    logic [PW-1:0] rem_r, val_r;
    logic [N-1:0] res_r;
    logic [SIDE_W-1:0] side_r;
    logic vld_r;
    logic [PW+1:0] cur, trial;
    always_comb begin
      cur   = {rem_q[k], val_q[k][PW-1 -: 2]};
      trial = (PW+2)'({res_q[k], 2'b01});
    end
    always_ff @(posedge clk) begin
      if (rst) vld_r <= 1'b0;
      else vld_r <= vld_q[k];
      side_r <= side_q[k];
      val_r  <= {val_q[k][PW-3:0], 2'b00};
      if (cur >= trial) begin
        rem_r <= PW'(cur - trial);
        res_r <= {res_q[k][N-2:0], 1'b1};
      end else begin
        rem_r <= PW'(cur);
        res_r <= {res_q[k][N-2:0], 1'b0};
      end
    end
    always_comb begin
      rem_q[k+1]  = rem_r;
      val_q[k+1]  = val_r;
      res_q[k+1]  = res_r;
      side_q[k+1] = side_r;
      vld_q[k+1]  = vld_r;
    end
  end

  assign out_valid = vld_q[N];
  assign root      = res_q[N];
  assign side_out  = side_q[N];

endmodule
`default_nettype wire

// ===== rtl/rmq_div.sv =====
// Pipelined signed-numerator divider, one quotient bit per stage,
// rounding half away from zero and saturating to 16 bits. Depends on rmq_pkg.
`default_nettype none
module rmq_div #(
  parameter int FRAC_BITS = 14,
  parameter int DEN_W = 24
) (
  input  wire logic                      clk,
  input  wire logic signed [rmq_pkg::NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0]          den,
  output logic signed [15:0]             quot
);
  import rmq_pkg::*;

  // q = (|n|*2^F + den/2) / den, capped at 65536; only QUOT_W bits matter.
  localparam int DW = NUM_W + FRAC_BITS + 1;
  localparam int NB = QUOT_W + 1;  // bits computed, top one flags overflow

  logic [DW-1:0]    dvd0;
  logic [DW-1:0]    dvd_q [NB+1];
  logic [DEN_W+NB:0] rem_q [NB+1];
  logic [NB-1:0]    q_q   [NB+1];
  logic [DEN_W-1:0] den_q [NB+1];
  logic             neg_q [NB+1];
  logic             big_q [NB+1];

  always_comb begin
    logic [NUM_W-1:0] mag;
    mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    dvd0 = (DW'(mag) << FRAC_BITS) + DW'(den >> 1);
    // Anything at or above den*2^NB saturates; high part folded in rem.
    dvd_q[0] = dvd0;
    rem_q[0] = (DEN_W+NB+1)'(dvd0 >> NB);
    q_q[0]   = '0;
    den_q[0] = den;
    neg_q[0] = num[NUM_W-1];
    big_q[0] = (dvd0 >> NB) >= DW'(den);
  end

  for (genvar k = 0; k < NB; k++) begin : g_st
    logic [DW-1:0] dvd_r;
    logic [DEN_W+NB:0] rem_r;
    logic [NB-1:0] q_r;
    logic [DEN_W-1:0] den_r;
    logic neg_r, big_r;
    logic [DEN_W+NB+1:0] cur;
    always_comb cur = {rem_q[k], dvd_q[k][NB-1-k]};
    always_ff @(posedge clk) begin
      dvd_r <= dvd_q[k];
      den_r <= den_q[k];
      neg_r <= neg_q[k];
      big_r <= big_q[k];
      if (cur >= (DEN_W+NB+2)'(den_q[k])) begin
        rem_r <= (DEN_W+NB+1)'(cur - (DEN_W+NB+2)'(den_q[k]));
        q_r   <= {q_q[k][NB-2:0], 1'b1};
      end else begin
        rem_r <= (DEN_W+NB+1)'(cur);
        q_r   <= {q_q[k][NB-2:0], 1'b0};
      end
    end
    always_comb begin
      dvd_q[k+1] = dvd_r;
      rem_q[k+1] = k == 0 ? (DEN_W+NB+1)'(0) | rem_r : rem_r;
      q_q[k+1]   = q_r;
      den_q[k+1] = den_r;
      neg_q[k+1] = neg_r;
      big_q[k+1] = big_r;
    end
  end

  always_comb begin
    logic [NB-1:0] q;
    q = q_q[NB];
    if (neg_q[NB]) begin
      quot = (big_q[NB] || q >= NB'(32768)) ? 16'sh8000 : 16'(-q);
    end else begin
      quot = (big_q[NB] || q >= NB'(32767)) ? 16'sh7fff : 16'(q);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to quaternion (Shepperd). Pipeline at FRAC_BITS=14:
// 1 input stage, (RAD_W+1)/2 = 16 square-root stages, 1 divisor stage,
// 18 divider stages, 1 output register. One item per cycle, busy is always low.
// Each bit-serial stage of the root and divider sets the depth.
// Synchronous reset clears the valid bits and the strobe.
// Depends on rmq_pkg, rmq_sqrt, rmq_div.
`default_nettype none
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire rmq_pkg::rmq_in_t  in_item,
  output logic                   done,
  output rmq_pkg::rmq_out_t      out_item
);
  import rmq_pkg::*;

  // trace and radicand hold 2^F plus three 16-bit terms, signed
  localparam int TR_W  = (FRAC_BITS > 15 ? FRAC_BITS : 15) + 3;
  localparam int RAD_W = TR_W + FRAC_BITS;  // radicand times 2^F
  localparam int RT_W  = (RAD_W + 1) / 2;
  localparam int DEN_W = RT_W + 1;
  localparam int SIDE_W = 2 + 3 * NUM_W;
  localparam int DIV_LAT = QUOT_W + 1;

  assign busy = 1'b0;

  // Stage 1: trace, branch pick, radicand and numerators.
  logic              s1_valid;
  branch_t           s1_branch;
  logic [TR_W-1:0]   s1_rad;
  logic signed [NUM_W-1:0] s1_na, s1_nb, s1_nc;

  always_ff @(posedge clk) begin
    logic signed [TR_W-1:0] a, b, c, one, tr;
    a   = TR_W'(in_item.m00);
    b   = TR_W'(in_item.m11);
    c   = TR_W'(in_item.m22);
    one = TR_W'(1) <<< FRAC_BITS;
    tr  = one + a + b + c;
    if (rst) s1_valid <= 1'b0;
    else s1_valid <= start;
    // na, nb, nc map to the non-dominant outputs in w,x,y,z order
    if (tr > 0) begin
      s1_branch <= BR_TRACE;
      s1_rad <= tr;
      s1_na <= NUM_W'(in_item.m21) - NUM_W'(in_item.m12);
      s1_nb <= NUM_W'(in_item.m02) - NUM_W'(in_item.m20);
      s1_nc <= NUM_W'(in_item.m10) - NUM_W'(in_item.m01);
    end else if (a >= b && a >= c) begin
      s1_branch <= BR_X;
      s1_rad <= one + a - b - c;
      s1_na <= NUM_W'(in_item.m21) - NUM_W'(in_item.m12);
      s1_nb <= NUM_W'(in_item.m01) + NUM_W'(in_item.m10);
      s1_nc <= NUM_W'(in_item.m02) + NUM_W'(in_item.m20);
    end else if (b >= c) begin
      s1_branch <= BR_Y;
      s1_rad <= one + b - a - c;
      s1_na <= NUM_W'(in_item.m02) - NUM_W'(in_item.m20);
      s1_nb <= NUM_W'(in_item.m01) + NUM_W'(in_item.m10);
      s1_nc <= NUM_W'(in_item.m12) + NUM_W'(in_item.m21);
    end else begin
      s1_branch <= BR_Z;
      s1_rad <= one + c - a - b;
      s1_na <= NUM_W'(in_item.m10) - NUM_W'(in_item.m01);
      s1_nb <= NUM_W'(in_item.m02) + NUM_W'(in_item.m20);
      s1_nc <= NUM_W'(in_item.m12) + NUM_W'(in_item.m21);
    end
  end

  logic [RAD_W-1:0] rad_fx;
  always_comb begin
    // radicand <= 0 clamps to 1 LSB
    if (s1_rad[TR_W-1] || s1_rad == '0) rad_fx = RAD_W'(1) << FRAC_BITS;
    else rad_fx = RAD_W'(s1_rad) << FRAC_BITS;
  end

  logic              sq_valid;
  logic [RT_W-1:0]   sq_root;
  logic [SIDE_W-1:0] sq_side;

  rmq_sqrt #(.RAD_W(RAD_W), .SIDE_W(SIDE_W)) u_sqrt (
    .clk(clk), .rst(rst), .in_valid(s1_valid), .rad(rad_fx),
    .side_in({s1_branch, s1_na, s1_nb, s1_nc}),
    .out_valid(sq_valid), .root(sq_root), .side_out(sq_side)
  );

  // Stage: register root, form divisor and dominant part.
  logic              s2_valid;
  branch_t           s2_branch;
  logic [DEN_W-1:0]  s2_den;
  logic signed [15:0] s2_dom;
  logic signed [NUM_W-1:0] s2_na, s2_nb, s2_nc;

  always_ff @(posedge clk) begin
    logic [RT_W:0] h;
    h = ((RT_W+1)'(sq_root) + 1'b1) >> 1;
    if (rst) s2_valid <= 1'b0;
    else s2_valid <= sq_valid;
    s2_branch <= branch_t'(sq_side[SIDE_W-1 -: 2]);
    s2_na <= sq_side[3*NUM_W-1 -: NUM_W];
    s2_nb <= sq_side[2*NUM_W-1 -: NUM_W];
    s2_nc <= sq_side[NUM_W-1:0];
    s2_den <= {sq_root, 1'b0};
    s2_dom <= (h > (RT_W+1)'(32767)) ? 16'sd32767 : 16'(h);
  end

  logic signed [15:0] qa, qb, qc;
  rmq_div #(.FRAC_BITS(FRAC_BITS), .DEN_W(DEN_W)) u_div_a (
    .clk(clk), .num(s2_na), .den(s2_den), .quot(qa));
  rmq_div #(.FRAC_BITS(FRAC_BITS), .DEN_W(DEN_W)) u_div_b (
    .clk(clk), .num(s2_nb), .den(s2_den), .quot(qb));
  rmq_div #(.FRAC_BITS(FRAC_BITS), .DEN_W(DEN_W)) u_div_c (
    .clk(clk), .num(s2_nc), .den(s2_den), .quot(qc));

  // Delay line for valid, branch and dominant part, matching the dividers.
  rmq_ctl_t          dl_ctl [DIV_LAT+1];
  logic signed [15:0] dl_dom [DIV_LAT+1];
  always_comb begin
    dl_ctl[0] = '{valid: s2_valid, branch: s2_branch};
    dl_dom[0] = s2_dom;
  end
  for (genvar k = 0; k < DIV_LAT; k++) begin : g_dl
    rmq_ctl_t ctl_r;
    logic signed [15:0] dom_r;
    always_ff @(posedge clk) begin
      if (rst) ctl_r.valid <= 1'b0;
      else ctl_r.valid <= dl_ctl[k].valid;
      ctl_r.branch <= dl_ctl[k].branch;
      dom_r <= dl_dom[k];
    end
    always_comb begin
      dl_ctl[k+1] = ctl_r;
      dl_dom[k+1] = dom_r;
    end
  end

  always_ff @(posedge clk) begin
    rmq_ctl_t c;
    c = dl_ctl[DIV_LAT];
    if (rst) done <= 1'b0;
    else done <= c.valid;
    out_item.branch_used <= c.branch;
    case (c.branch)
      BR_TRACE: begin
        out_item.quat_w <= dl_dom[DIV_LAT];
        out_item.quat_x <= qa; out_item.quat_y <= qb; out_item.quat_z <= qc;
      end
      BR_X: begin
        out_item.quat_x <= dl_dom[DIV_LAT];
        out_item.quat_w <= qa; out_item.quat_y <= qb; out_item.quat_z <= qc;
      end
      BR_Y: begin
        out_item.quat_y <= dl_dom[DIV_LAT];
        out_item.quat_w <= qa; out_item.quat_x <= qb; out_item.quat_z <= qc;
      end
      default: begin
        out_item.quat_z <= dl_dom[DIV_LAT];
        out_item.quat_w <= qa; out_item.quat_x <= qb; out_item.quat_y <= qc;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== dv/rotation_matrix_to_quaternion_tb.sv =====
// Testbench for rotation_matrix_to_quaternion: directed table plus random matrices,
// each checked per field against a table entry or an in-bench Shepperd predictor.
// Depends on rmq_pkg and the rotation_matrix_to_quaternion RTL.
module rotation_matrix_to_quaternion_tb;
  import rmq_pkg::*;

  localparam int FRAC = 14;
  localparam int LATENCY = 1 + (FRAC + 18) / 2 + 1 + 18 + 1;
  localparam int NUM_RANDOM = 1530;
  localparam longint CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  rmq_in_t in_item = '0;
  logic done;
  rmq_out_t out_item;

  rmq_out_t quat_queue[$];
  int errors = 0;
  longint cycles = 0;
  bit quiet_tail = 1'b0;

  typedef struct {
    rmq_in_t mat;
    bit has_exp;
    rmq_out_t exp_q;
  } row_t;
  row_t rows[$];

  rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_item(in_item), .done(done), .out_item(out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint root_fx(longint rad);
    longint v, res, b;
    v = (rad <= 0) ? 1 : rad;
    v = v << FRAC;
    res = 0;
    b = 64'sd1 << 60;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] quot_fx(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    if (den == 0) den = 1;
    q = ((mag << FRAC) + den / 2) / den;
    if (q > 65536) q = 65536;
    if (num < 0) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic logic signed [15:0] halve_fx(longint r);
    longint h;
    h = (r + 1) >> 1;
    if (h > 32767) h = 32767;
    return h[15:0];
  endfunction

  function automatic rmq_out_t quat_from_matrix(rmq_in_t m);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, one, tr, r, s;
    rmq_out_t q;
    a00 = longint'(m.m00); a01 = longint'(m.m01); a02 = longint'(m.m02);
    a10 = longint'(m.m10); a11 = longint'(m.m11); a12 = longint'(m.m12);
    a20 = longint'(m.m20); a21 = longint'(m.m21); a22 = longint'(m.m22);
    one = 64'sd1 << FRAC;
    tr = one + a00 + a11 + a22;
    if (tr > 0) begin
      r = root_fx(tr); s = 2 * r;
      q.quat_w = halve_fx(r);
      q.quat_x = quot_fx(a21 - a12, s);
      q.quat_y = quot_fx(a02 - a20, s);
      q.quat_z = quot_fx(a10 - a01, s);
      q.branch_used = BR_TRACE;
    end else if (a00 >= a11 && a00 >= a22) begin
      r = root_fx(one + a00 - a11 - a22); s = 2 * r;
      q.quat_x = halve_fx(r);
      q.quat_y = quot_fx(a01 + a10, s);
      q.quat_z = quot_fx(a02 + a20, s);
      q.quat_w = quot_fx(a21 - a12, s);
      q.branch_used = BR_X;
    end else if (a11 >= a22) begin
      r = root_fx(one + a11 - a00 - a22); s = 2 * r;
      q.quat_y = halve_fx(r);
      q.quat_x = quot_fx(a01 + a10, s);
      q.quat_z = quot_fx(a12 + a21, s);
      q.quat_w = quot_fx(a02 - a20, s);
      q.branch_used = BR_Y;
    end else begin
      r = root_fx(one + a22 - a00 - a11); s = 2 * r;
      q.quat_z = halve_fx(r);
      q.quat_x = quot_fx(a02 + a20, s);
      q.quat_y = quot_fx(a12 + a21, s);
      q.quat_w = quot_fx(a10 - a01, s);
      q.branch_used = BR_Z;
    end
    return q;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // results cannot be held off; check every strobe
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (quat_queue.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        rmq_out_t e;
        e = quat_queue.pop_front();
        if (out_item.quat_w !== e.quat_w)
          report_mismatch("quat_w", int'(out_item.quat_w), int'(e.quat_w));
        if (out_item.quat_x !== e.quat_x)
          report_mismatch("quat_x", int'(out_item.quat_x), int'(e.quat_x));
        if (out_item.quat_y !== e.quat_y)
          report_mismatch("quat_y", int'(out_item.quat_y), int'(e.quat_y));
        if (out_item.quat_z !== e.quat_z)
          report_mismatch("quat_z", int'(out_item.quat_z), int'(e.quat_z));
        if (out_item.branch_used !== e.branch_used)
          report_mismatch("branch_used", int'(out_item.branch_used),
                          int'(e.branch_used));
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("rotation_matrix_to_quaternion_tb: FAIL");
      $finish;
    end
  end

  function automatic rmq_in_t diag(int d0, int d1, int d2);
    rmq_in_t m;
    m = '0;
    m.m00 = 16'(d0); m.m11 = 16'(d1); m.m22 = 16'(d2);
    return m;
  endfunction

  function automatic rmq_out_t quat_lit(int w, int x, int y, int z, branch_t b);
    rmq_out_t q;
    q.quat_w = 16'(w); q.quat_x = 16'(x); q.quat_y = 16'(y); q.quat_z = 16'(z);
    q.branch_used = b;
    return q;
  endfunction

  task automatic add_row(rmq_in_t m, bit has, rmq_out_t q);
    row_t r;
    r.mat = m; r.has_exp = has; r.exp_q = q;
    rows.push_back(r);
  endtask

  function automatic rmq_in_t rand_matrix();
    rmq_in_t m;
    int c;
    c = $urandom_range(0, 9);
    if (c < 7) begin
      // near-rotation: diagonals and off-diagonals in +-1.0
      m.m00 = 16'($urandom_range(0, 32768) - 16384);
      m.m11 = 16'($urandom_range(0, 32768) - 16384);
      m.m22 = 16'($urandom_range(0, 32768) - 16384);
      m.m01 = 16'($urandom_range(0, 32768) - 16384);
      m.m02 = 16'($urandom_range(0, 32768) - 16384);
      m.m10 = 16'($urandom_range(0, 32768) - 16384);
      m.m12 = 16'($urandom_range(0, 32768) - 16384);
      m.m20 = 16'($urandom_range(0, 32768) - 16384);
      m.m21 = 16'($urandom_range(0, 32768) - 16384);
      if (c >= 4) begin
        // lower each diagonal by 1.0 so the diagonal branches get exercised
        m.m00 = 16'(m.m00 - 16384);
        m.m11 = 16'(m.m11 - 16384);
        m.m22 = 16'(m.m22 - 16384);
        if (c == 6) m.m11 = m.m00; // tie
      end
    end else begin
      m = 144'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
    end
    return m;
  endfunction

  // drives start and the item, waits until it is accepted, then queues the expected result
  task automatic send(rmq_in_t m, rmq_out_t q);
    start <= 1'b1;
    in_item <= m;
    @(posedge clk);
    while (busy) @(posedge clk);
    quat_queue.push_back(q);
  endtask

  task automatic idle_burst();
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  initial begin
    rmq_in_t m;
    rmq_out_t nq;
    nq = '0;
    // directed rows
    add_row(diag(16384, 16384, 16384), 1, quat_lit(16384, 0, 0, 0, BR_TRACE));
    add_row(diag(16384, -16384, -16384), 1, quat_lit(0, 16384, 0, 0, BR_X));
    add_row(diag(-16384, 16384, -16384), 1, quat_lit(0, 0, 16384, 0, BR_Y));
    add_row(diag(-16384, -16384, 16384), 1, quat_lit(0, 0, 0, 16384, BR_Z));
    add_row(diag(-16384, -16384, -16384), 0, nq); // x/y/z tie
    add_row(diag(-32768, -32768, -32768), 0, nq);
    add_row(diag(32767, 32767, 32767), 0, nq);
    add_row(diag(-8192, -8192, 0), 0, nq);        // trace exactly zero
    add_row(diag(-16384, -8192, -8192), 0, nq);   // y/z tie
    m = '1; add_row(m, 0, nq);
    m = {9{16'sh7fff}}; add_row(m, 0, nq);
    m = {9{16'sh8000}}; add_row(m, 0, nq);
    m = diag(-32768, -32768, 32767); m.m01 = 16'sh7fff; m.m10 = 16'sh7fff;
    m.m02 = 16'sh8000; m.m20 = 16'sh8000; add_row(m, 0, nq);
    m = diag(-32768, -32768, -32768); m.m21 = 16'sh7fff; m.m12 = 16'sh8000;
    add_row(m, 0, nq);
    m = diag(16384, -32768, -32768); m.m01 = 16'sh7fff; m.m10 = 16'sh7fff;
    add_row(m, 0, nq);
    m = '0; m.m10 = 16'sh7fff; m.m01 = 16'sh8000; add_row(m, 0, nq);
    m = {16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
         16'haaaa, 16'h5555};
    add_row(m, 0, nq);
    add_row(~m, 0, nq);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      send(rows[i].mat, rows[i].has_exp ? rows[i].exp_q : quat_from_matrix(rows[i].mat));
      idle_burst();
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 2) begin
        start <= 1'b0;
        wait (quat_queue.size() == 0);
        @(posedge clk);
      end
      if (n == NUM_RANDOM - 300) quiet_tail = 1'b1;
      m = rand_matrix();
      send(m, quat_from_matrix(m));
      idle_burst();
    end

    start <= 1'b0;
    while (quat_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("rotation_matrix_to_quaternion_tb: PASS");
    end else begin
      $display("rotation_matrix_to_quaternion_tb: FAIL");
    end
    $finish;
  end

endmodule
